### sv/i2c_ws_pkg.sv
// Shared types and constants for the write-only I2C serializer.
package i2c_ws_pkg;

    localparam int unsigned AddrWidth = 7;
    localparam int unsigned ByteWidth = 8;
    localparam logic [3:0]  AckSlot   = 4'd8;

    typedef struct packed {
        logic [ByteWidth-1:0] payload_byte;
        logic                 open_transaction;
        logic                 close_transaction;
    } t_item;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic lines_driven;
        logic last_phase;
    } t_phase;

    typedef enum logic [4:0] {
        SEG_IDLE  = 5'b00001,
        SEG_START = 5'b00010,
        SEG_ADDR  = 5'b00100,
        SEG_DATA  = 5'b01000,
        SEG_STOP  = 5'b10000
    } t_seg;

endpackage

### sv/i2c_ws_in_reg.sv
// Input holding register that decouples the input handshake from the phase sequencer.
module i2c_ws_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  i2c_ws_pkg::t_item i_item,
    output logic              o_item_valid,
    output i2c_ws_pkg::t_item o_item,
    input  logic              i_take
);

    logic              r_valid;
    i2c_ws_pkg::t_item r_item;
    logic              accept;

    assign o_ready      = !r_valid || i_take;
    assign accept       = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

### sv/i2c_ws_phase_gen.sv
// Bus phase sequencer with registered phase output.
module i2c_ws_phase_gen (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_item_valid,
    input  i2c_ws_pkg::t_item                i_item,
    output logic                             o_item_take,
    input  logic [i2c_ws_pkg::AddrWidth-1:0] i_slave_address,
    output logic                             o_out_valid,
    output i2c_ws_pkg::t_phase               o_phase,
    input  logic                             i_out_ready
);

    i2c_ws_pkg::t_seg                  r_seg, n_seg;
    logic [1:0]                        r_sub, n_sub;
    logic [3:0]                        r_bit, n_bit;
    logic [i2c_ws_pkg::ByteWidth-1:0]  r_shift, n_shift;
    logic [i2c_ws_pkg::ByteWidth-1:0]  r_byte, n_byte;
    logic                              r_close, n_close;
    logic                              r_bus_open, n_bus_open;
    logic                              r_out_valid, n_out_valid;
    i2c_ws_pkg::t_phase                r_phase, n_phase;

    logic               adv;
    logic               emit;
    logic               byte_end;
    logic               item_done;
    logic               take;
    i2c_ws_pkg::t_phase cur;

    always_comb begin
        cur = '0;
        case (r_seg)
            i2c_ws_pkg::SEG_START: begin
                cur.scl_level    = (r_sub != 2'd2);
                cur.sda_level    = (r_sub == 2'd0);
                cur.lines_driven = 1'b1;
            end
            i2c_ws_pkg::SEG_ADDR, i2c_ws_pkg::SEG_DATA: begin
                cur.scl_level    = (r_sub == 2'd1);
                cur.sda_level    = r_shift[i2c_ws_pkg::ByteWidth-1];
                cur.lines_driven = 1'b1;
            end
            i2c_ws_pkg::SEG_STOP: begin
                cur.scl_level    = (r_sub != 2'd0);
                cur.sda_level    = r_sub[1];
                cur.lines_driven = (r_sub != 2'd3);
            end
            default: begin
                cur = '0;
            end
        endcase

        adv      = !r_out_valid || i_out_ready;
        emit     = adv && (r_seg != i2c_ws_pkg::SEG_IDLE);
        byte_end = (r_sub == 2'd2) && (r_bit == i2c_ws_pkg::AckSlot);
        item_done = emit && (((r_seg == i2c_ws_pkg::SEG_DATA) && byte_end && !r_close)
                            || ((r_seg == i2c_ws_pkg::SEG_STOP) && (r_sub == 2'd3)));
        cur.last_phase = item_done;
        take = i_item_valid && ((r_seg == i2c_ws_pkg::SEG_IDLE) || item_done);

        n_seg       = r_seg;
        n_sub       = r_sub;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_byte      = r_byte;
        n_close     = r_close;
        n_bus_open  = r_bus_open;
        n_out_valid = r_out_valid;
        n_phase     = r_phase;

        if (emit) begin
            n_out_valid = 1'b1;
            n_phase     = cur;
        end else if (adv) begin
            n_out_valid = 1'b0;
        end

        if (emit) begin
            case (r_seg)
                i2c_ws_pkg::SEG_START: begin
                    if (r_sub == 2'd2) begin
                        n_seg   = i2c_ws_pkg::SEG_ADDR;
                        n_sub   = 2'd0;
                        n_bit   = 4'd0;
                        n_shift = {i_slave_address, 1'b0};
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                i2c_ws_pkg::SEG_ADDR, i2c_ws_pkg::SEG_DATA: begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        if (byte_end) begin
                            n_bit = 4'd0;
                            if (r_seg == i2c_ws_pkg::SEG_ADDR) begin
                                n_seg   = i2c_ws_pkg::SEG_DATA;
                                n_shift = r_byte;
                            end else if (r_close) begin
                                n_seg = i2c_ws_pkg::SEG_STOP;
                            end else begin
                                n_seg = i2c_ws_pkg::SEG_IDLE;
                            end
                        end else begin
                            n_bit   = r_bit + 4'd1;
                            n_shift = {r_shift[i2c_ws_pkg::ByteWidth-2:0], 1'b0};
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                i2c_ws_pkg::SEG_STOP: begin
                    if (r_sub == 2'd3) begin
                        n_seg = i2c_ws_pkg::SEG_IDLE;
                        n_sub = 2'd0;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                default: begin
                    n_seg = i2c_ws_pkg::SEG_IDLE;
                end
            endcase
        end

        if (take) begin
            n_sub   = 2'd0;
            n_bit   = 4'd0;
            n_byte  = i_item.payload_byte;
            n_shift = i_item.payload_byte;
            n_close = i_item.close_transaction;
            if (i_item.open_transaction) begin
                n_seg      = i2c_ws_pkg::SEG_START;
                n_bus_open = !i_item.close_transaction;
            end else if (r_bus_open) begin
                n_seg      = i2c_ws_pkg::SEG_DATA;
                n_bus_open = !i_item.close_transaction;
            end else begin
                n_seg = i2c_ws_pkg::SEG_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= i2c_ws_pkg::SEG_IDLE;
            r_sub       <= 2'd0;
            r_bit       <= 4'd0;
            r_close     <= 1'b0;
            r_bus_open  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seg       <= n_seg;
            r_sub       <= n_sub;
            r_bit       <= n_bit;
            r_close     <= n_close;
            r_bus_open  <= n_bus_open;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_byte  <= n_byte;
        r_phase <= n_phase;
    end

    assign o_item_take = take;
    assign o_out_valid = r_out_valid;
    assign o_phase     = r_phase;

endmodule

### sv/i2c_write_serializer_unit.sv
// Top level of the write-only I2C serializer: address register, input register and sequencer.
// From idle, an accepted word passes the input register and the sequencer state before its first
// bus phase is registered at the output. One bus phase per cycle while i_out_ready does not stall
// the output; a word gives 27, 31, 57 or 61 phases, and a word ignored while no transaction is
// open gives none. The next word is held in the input register while the current one is sent.
// Reset is synchronous and active low; it clears the address to zero and closes the bus.
module i2c_write_serializer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_payload_byte,
    input  logic       i_open_transaction,
    input  logic       i_close_transaction,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_lines_driven,
    output logic       o_last_phase,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data
);

    logic [i2c_ws_pkg::AddrWidth-1:0] r_slave_address;
    i2c_ws_pkg::t_item                in_item;
    i2c_ws_pkg::t_item                held_item;
    logic                             held_valid;
    logic                             take;
    i2c_ws_pkg::t_phase               phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= '0;
        end else if (i_cfg_we) begin
            r_slave_address <= i_cfg_data;
        end
    end

    assign in_item.payload_byte      = i_payload_byte;
    assign in_item.open_transaction  = i_open_transaction;
    assign in_item.close_transaction = i_close_transaction;

    i2c_ws_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (in_item),
        .o_item_valid (held_valid),
        .o_item       (held_item),
        .i_take       (take)
    );

    i2c_ws_phase_gen u_phase_gen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (held_valid),
        .i_item          (held_item),
        .o_item_take     (take),
        .i_slave_address (r_slave_address),
        .o_out_valid     (o_out_valid),
        .o_phase         (phase),
        .i_out_ready     (i_out_ready)
    );

    assign o_scl_level    = phase.scl_level;
    assign o_sda_level    = phase.sda_level;
    assign o_lines_driven = phase.lines_driven;
    assign o_last_phase   = phase.last_phase;

endmodule

### sv/i2c_ws_checker.sv
// Port-level checker for the write-only I2C serializer, bound to the top level.
module i2c_ws_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_scl_level,
    input logic o_sda_level,
    input logic o_lines_driven,
    input logic o_last_phase
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word present after reset");

    a_release_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_lines_driven) |-> o_last_phase)
        else $error("line release is not the final phase of its word");

    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_lines_driven) |-> (o_scl_level && o_sda_level))
        else $error("released phase does not show both lines high");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_scl_level)
            && $stable(o_sda_level) && $stable(o_lines_driven) && $stable(o_last_phase)))
        else $error("stalled output word changed");

endmodule

bind i2c_write_serializer_unit i2c_ws_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_scl_level    (o_scl_level),
    .o_sda_level    (o_sda_level),
    .o_lines_driven (o_lines_driven),
    .o_last_phase   (o_last_phase)
);

### tb/i2c_write_serializer_unit_test.sv
// Testbench for the write-only I2C serializer: random words with predicted bus phases.
`timescale 1ns / 100ps

module i2c_write_serializer_unit_test;
    import i2c_ws_pkg::*;

    class phase_scoreboard;
        logic [AddrWidth-1:0] address;
        bit                   bus_open;
        t_phase               expected_phases[$];
        int                   mismatches;

        function new();
            address    = '0;
            bus_open   = 1'b0;
            mismatches = 0;
        endfunction

        function void add_phase(bit scl, bit sda, bit drv);
            t_phase p;
            p.scl_level    = scl;
            p.sda_level    = sda;
            p.lines_driven = drv;
            p.last_phase   = 1'b0;
            expected_phases.push_back(p);
        endfunction

        function void add_byte(logic [ByteWidth-1:0] value);
            for (int i = ByteWidth - 1; i >= 0; i--) begin
                add_phase(1'b0, value[i], 1'b1);
                add_phase(1'b1, value[i], 1'b1);
                add_phase(1'b0, value[i], 1'b1);
            end
            add_phase(1'b0, 1'b0, 1'b1);
            add_phase(1'b1, 1'b0, 1'b1);
            add_phase(1'b0, 1'b0, 1'b1);
        endfunction

        function void note_word(t_item w);
            t_phase tail;
            if (!w.open_transaction && !bus_open)
                return;
            if (w.open_transaction) begin
                add_phase(1'b1, 1'b1, 1'b1);
                add_phase(1'b1, 1'b0, 1'b1);
                add_phase(1'b0, 1'b0, 1'b1);
                add_byte({address, 1'b0});
                bus_open = 1'b1;
            end
            add_byte(w.payload_byte);
            if (w.close_transaction) begin
                add_phase(1'b0, 1'b0, 1'b1);
                add_phase(1'b1, 1'b0, 1'b1);
                add_phase(1'b1, 1'b1, 1'b1);
                add_phase(1'b1, 1'b1, 1'b0);
                bus_open = 1'b0;
            end
            tail = expected_phases.pop_back();
            tail.last_phase = 1'b1;
            expected_phases.push_back(tail);
        endfunction

        task note_mismatch(string what);
            mismatches++;
            $display("%0t: %s", $time, what);
        endtask

        task check_phase(t_phase got);
            t_phase want;
            if (expected_phases.size() == 0) begin
                note_mismatch($sformatf("unexpected bus phase %b", got));
                return;
            end
            want = expected_phases.pop_front();
            if (got.scl_level !== want.scl_level)
                note_mismatch($sformatf("scl %b, expected %b", got.scl_level, want.scl_level));
            if (got.sda_level !== want.sda_level)
                note_mismatch($sformatf("sda %b, expected %b", got.sda_level, want.sda_level));
            if (got.lines_driven !== want.lines_driven)
                note_mismatch($sformatf("drive %b, expected %b",
                                        got.lines_driven, want.lines_driven));
            if (got.last_phase !== want.last_phase)
                note_mismatch($sformatf("last phase %b, expected %b",
                                        got.last_phase, want.last_phase));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ByteWidth-1:0] i_payload_byte;
    logic                 i_open_transaction;
    logic                 i_close_transaction;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_scl_level;
    logic                 o_sda_level;
    logic                 o_lines_driven;
    logic                 o_last_phase;
    logic                 i_cfg_we;
    logic [AddrWidth-1:0] i_cfg_data;

    phase_scoreboard sb;
    t_item           word_q[$];
    bit              idle_en;

    i2c_write_serializer_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_payload_byte      (i_payload_byte),
        .i_open_transaction  (i_open_transaction),
        .i_close_transaction (i_close_transaction),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_scl_level         (o_scl_level),
        .o_sda_level         (o_sda_level),
        .o_lines_driven      (o_lines_driven),
        .o_last_phase        (o_last_phase),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int draw_gap();
        return idle_en ? int'($urandom_range(0, 15)) : 0;
    endfunction

    function automatic void queue_word(logic [ByteWidth-1:0] b, bit op, bit cl);
        t_item w;
        w.payload_byte      = b;
        w.open_transaction  = op;
        w.close_transaction = cl;
        word_q.push_back(w);
    endfunction

    function automatic logic [ByteWidth-1:0] random_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_words();
        t_item w;
        int    gap;
        @(posedge i_clk);
        gap = draw_gap();
        while (word_q.size() > 0) begin
            w = word_q.pop_front();
            repeat (gap) @(posedge i_clk);
            i_in_valid          <= 1'b1;
            i_payload_byte      <= w.payload_byte;
            i_open_transaction  <= w.open_transaction;
            i_close_transaction <= w.close_transaction;
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_word(w);
            gap = draw_gap();
            if (word_q.size() == 0 || gap > 0)
                i_in_valid <= 1'b0;
        end
    endtask

    task automatic wait_drain();
        while (sb.expected_phases.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_address(logic [AddrWidth-1:0] a);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.address = a;
    endtask

    // Mostly well-formed transactions, with stray words while idle and the odd repeated start.
    task automatic build_random(int target);
        int count;
        int r;
        bit gen_open;
        count    = 0;
        gen_open = sb.bus_open;
        while (count < target) begin
            r = $urandom_range(0, 99);
            if (!gen_open) begin
                if (r < 10) begin
                    queue_word(random_byte(), 1'b0, 1'($urandom_range(0, 1)));
                end else begin
                    queue_word(random_byte(), 1'b1, r < 25);
                    gen_open = !(r < 25);
                    count++;
                end
            end else begin
                if (r < 8) begin
                    queue_word(random_byte(), 1'b1, r < 4);
                    gen_open = !(r < 4);
                end else begin
                    queue_word(random_byte(), 1'b0, r < 35);
                    gen_open = !(r < 35);
                end
                count++;
            end
        end
    endtask

    initial begin
        t_phase got;
        int     gap;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_scl_level, o_sda_level, o_lines_driven, o_last_phase};
            sb.check_phase(got);
        end
    end

    initial begin
        logic [AddrWidth-1:0] addr;
        sb      = new();
        idle_en = 1'b1;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_payload_byte      <= '0;
        i_open_transaction  <= 1'b0;
        i_close_transaction <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stray words while idle are dropped; a repeated start resends the address.
        queue_word(8'h5a, 1'b0, 1'b1);
        queue_word(8'h00, 1'b1, 1'b0);
        queue_word(8'hff, 1'b0, 1'b0);
        queue_word(8'h80, 1'b1, 1'b0);
        queue_word(8'h01, 1'b0, 1'b1);
        queue_word(8'h3c, 1'b0, 1'b0);
        send_words();
        wait_drain();
        write_address(7'h7f);
        queue_word(8'hff, 1'b1, 1'b1);
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'h7e, 1'b1, 1'b0);
        send_words();
        wait_drain();
        // The new address must only show after the next start.
        write_address(7'h2a);
        queue_word(8'h81, 1'b0, 1'b0);
        queue_word(8'h55, 1'b1, 1'b1);
        send_words();
        wait_drain();
        write_address(7'h55);
        queue_word(8'hc3, 1'b1, 1'b0);
        queue_word(8'haa, 1'b0, 1'b1);
        send_words();

        for (int p = 0; p < 4; p++) begin
            wait_drain();
            addr = (p == 2) ? 7'h00 : 7'($urandom_range(0, 127));
            write_address(addr);
            idle_en = (p != 1);
            build_random(28);
            send_words();
        end

        wait_drain();
        repeat (50) @(posedge i_clk);
        if (sb.expected_phases.size() != 0)
            sb.note_mismatch("bus phases still outstanding at the end");
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
